// ----- sv/alru_pkg.sv -----
package alru_pkg;

  // default sizing
  localparam int DEF_NUM_SETS    = 2048;
  localparam int DEF_NUM_WAYS    = 16;
  localparam int DEF_WINDOW      = 128;
  localparam int DEF_INSERT_ODDS = 32;

  // fixed field widths
  localparam int SET_IDX_W = 11;
  localparam int WAY_W     = 4;
  localparam int POS_W     = 4;
  localparam int RRPV_W    = 2;
  localparam int THR_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int LFSR_W    = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
  localparam logic [RRPV_W-1:0] RRPV_MAX   = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_SHORT = 2'd1;
  localparam logic [RRPV_W-1:0] RRPV_HIT   = 2'd0;

  localparam logic [THR_W-1:0] STREAM_MISS_RESET = 8'd89;
  localparam logic [THR_W-1:0] REUSE_RESET       = 8'd32;

  typedef enum logic {
    CMD_QUERY  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic {
    POL_BRRIP = 1'b0,
    POL_LRU   = 1'b1
  } policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STREAM_MISS = 1'b0,
    REG_REUSE       = 1'b1
  } cfg_reg_t;

endpackage

// ----- sv/alru_if.sv -----
interface alru_in_if
  import alru_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_W-1:0]     way;
  logic                 hit;

  modport source (output valid, output cmd, output set_index, output way, output hit,
                  input ready);
  modport sink   (input valid, input cmd, input set_index, input way, input hit,
                  output ready);
endinterface

interface alru_out_if
  import alru_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WAY_W-1:0] victim_way;
  logic             policy_mode;

  modport source (output valid, output victim_way, output policy_mode, input ready);
  modport sink   (input valid, input victim_way, input policy_mode, output ready);
endinterface

interface alru_cfg_if
  import alru_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/adaptive_lru_brrip_replacement_top.sv -----
// channel   dir  handshake     payload
// in_ch     in   valid/ready   cmd, set_index, way, hit
// out_ch    out  valid/ready   victim_way, policy_mode
// cfg_ch    in   valid/ready   index, data (ready always high)
//
// when NUM_SETS and INSERT_ODDS are powers of two a transaction is accept plus
// row read, then modify and write back; otherwise a reciprocal remainder unit
// (quotient step, then remainder step) and a row read state come in between
// the set row memory (one read-modify-write per transaction) sets the rate
// after reset a clearing pass initializes every row, in_ch not ready
// a stalled result holds in the output register; the next transaction is still
// accepted, and its write back waits until the register is free
module adaptive_lru_brrip_replacement_top
  import alru_pkg::*;
#(
  parameter int NUM_SETS    = DEF_NUM_SETS,
  parameter int NUM_WAYS    = DEF_NUM_WAYS,
  parameter int WINDOW      = DEF_WINDOW,
  parameter int INSERT_ODDS = DEF_INSERT_ODDS
) (
  input  logic       clk,
  input  logic       rst_n,
  alru_in_if.sink    in_ch,
  alru_out_if.source out_ch,
  alru_cfg_if.sink   cfg_ch
);

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ACC_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CMP_W  = THR_W + 1;
  localparam int ODDS_W = $clog2(INSERT_ODDS);
  localparam int ROW_W  = 1 + ACC_W + 2 * CNT_W + (POS_W + RRPV_W) * NUM_WAYS;

  // reciprocal remainder: q = (x * ceil(2^k / d)) >> k is exact for 16-bit x
  // when k = 16 + clog2(d)
  localparam int RCP_W  = LFSR_W + 2;
  localparam int PROD_W = LFSR_W + RCP_W;
  localparam int SET_K  = LFSR_W + SET_W;
  localparam int ODDS_K = LFSR_W + ODDS_W;
  localparam logic [RCP_W-1:0] SET_RCP =
    RCP_W'(((64'd1 << SET_K) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
  localparam logic [RCP_W-1:0] ODDS_RCP =
    RCP_W'(((64'd1 << ODDS_K) + 64'(INSERT_ODDS) - 64'd1) / 64'(INSERT_ODDS));
  localparam logic [LFSR_W-1:0] SET_D  = LFSR_W'(NUM_SETS);
  localparam logic [LFSR_W-1:0] ODDS_D = LFSR_W'(INSERT_ODDS);

  localparam bit SETS_POW2   = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam bit ODDS_POW2   = (INSERT_ODDS & (INSERT_ODDS - 1)) == 0;
  localparam bit NEED_REDUCE = !(SETS_POW2 && ODDS_POW2);

  localparam logic [SET_W-1:0]  SET_LAST  = SET_W'(NUM_SETS - 1);
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(NUM_WAYS - 1);

  // per-set row as held in memory
  typedef struct packed {
    policy_t                      pol;
    logic [ACC_W-1:0]             acc;
    logic [CNT_W-1:0]             miss;
    logic [CNT_W-1:0]             reuse;
    logic [POS_W*NUM_WAYS-1:0]    lru;
    logic [RRPV_W*NUM_WAYS-1:0]   rrpv;
  } row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_CALC
  } state_t;

  state_t state_r, state_nxt;

  // latched transaction
  cmd_t              cmd_r;
  logic [WAY_W-1:0]  way_r;
  logic              hit_r;
  logic [SET_W-1:0]  set_r;
  logic              short_r;
  logic [LFSR_W-1:0] cand_r;

  // remainder unit
  logic [LFSR_W-1:0] src_set_r;
  logic [LFSR_W-1:0] quo_set_r, quo_odds_r;
  logic [LFSR_W-1:0] quo_set, quo_odds;
  logic [LFSR_W-1:0] rem_set, rem_odds;
  logic [PROD_W-1:0] prod_set, prod_odds;
  logic              step_r;

  logic [SET_W-1:0]  clr_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [LFSR_W-1:0] lfsr_step;
  logic [THR_W-1:0]  stream_thr_r, reuse_thr_r;

  logic              out_valid_r;
  logic [WAY_W-1:0]  out_victim_r;
  policy_t           out_policy_r;

  // memory port
  logic              ram_we, ram_re;
  logic [SET_W-1:0]  ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  logic              in_acc;
  logic              go;
  logic [LFSR_W-1:0] in_set_wide;
  logic [SET_W-1:0]  in_set_idx;

  row_t              row_rd, wr_row, rst_row;
  logic [RRPV_W-1:0] rrpv_cur  [NUM_WAYS];
  logic [RRPV_W-1:0] rrpv_aged [NUM_WAYS];
  logic [POS_W-1:0]  lru_cur   [NUM_WAYS];
  logic              any3, any2, any1;
  logic [RRPV_W-1:0] age;
  logic              way_ok;
  logic [POS_W-1:0]  lru_pos;
  logic [ACC_W:0]    acc_inc;
  logic [CNT_W-1:0]  miss_inc, reuse_inc;
  logic              wrap;
  policy_t           new_pol;
  logic [WAY_W-1:0]  victim;
  policy_t           pol_out;
  logic              adv_lfsr;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.victim_way  = out_victim_r;
  assign out_ch.policy_mode = out_policy_r;

  assign go = (state_r == ST_CALC) && (!out_valid_r || out_ch.ready);

  // set index reduction for power-of-two set counts
  assign in_set_wide = LFSR_W'(in_ch.set_index);
  assign in_set_idx  = in_set_wide[SET_W-1:0] & SET_LAST;

  // x^16+x^14+x^13+x^11+1, shift right
  assign lfsr_step = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[LFSR_W-1:1]};

  // quotient on the first reduce step, remainder x - q*d on the second
  assign prod_set  = PROD_W'(src_set_r) * PROD_W'(SET_RCP);
  assign prod_odds = PROD_W'(cand_r) * PROD_W'(ODDS_RCP);
  assign quo_set   = LFSR_W'(prod_set >> SET_K);
  assign quo_odds  = LFSR_W'(prod_odds >> ODDS_K);
  assign rem_set   = src_set_r - quo_set_r * SET_D;
  assign rem_odds  = cand_r - quo_odds_r * ODDS_D;

  // row memory access
  assign ram_re    = (in_acc && !NEED_REDUCE) || (state_r == ST_READ);
  assign ram_raddr = (state_r == ST_READ) ? set_r : in_set_idx;
  assign ram_we    = (state_r == ST_CLEAR) || go;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : set_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? ROW_W'(rst_row) : ROW_W'(wr_row);
  assign row_rd    = row_t'(ram_rdata);

  alru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS),
    .ADDR_W(SET_W)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // reset row: policy brrip, counts zero, way w at stack position w, rrpv max
  always_comb begin
    rst_row = '0;
    rst_row.pol = POL_BRRIP;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rst_row.lru[w*POS_W +: POS_W]    = POS_W'(w);
      rst_row.rrpv[w*RRPV_W +: RRPV_W] = RRPV_MAX;
    end
  end

  // unpack the row and age the rrpvs
  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrpv_cur[w] = row_rd.rrpv[w*RRPV_W +: RRPV_W];
      lru_cur[w]  = row_rd.lru[w*POS_W +: POS_W];
      any3 = any3 | (rrpv_cur[w] == 2'd3);
      any2 = any2 | (rrpv_cur[w] == 2'd2);
      any1 = any1 | (rrpv_cur[w] == 2'd1);
    end
    // age = max rrpv minus current max
    if (any3) begin
      age = 2'd0;
    end else if (any2) begin
      age = 2'd1;
    end else if (any1) begin
      age = 2'd2;
    end else begin
      age = 2'd3;
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrpv_aged[w] = rrpv_cur[w] + age;
    end
  end

  // window counting and policy choice
  always_comb begin
    way_ok    = {1'b0, way_r} < (WAY_W + 1)'(NUM_WAYS);
    acc_inc   = {1'b0, row_rd.acc} + (ACC_W + 1)'(1);
    miss_inc  = row_rd.miss + CNT_W'(!hit_r);
    reuse_inc = row_rd.reuse + CNT_W'(hit_r);
    wrap      = acc_inc >= (ACC_W + 1)'(WINDOW);
    if (!wrap) begin
      new_pol = row_rd.pol;
    end else if (CMP_W'(miss_inc) > CMP_W'(stream_thr_r)) begin
      new_pol = POL_BRRIP;
    end else if (CMP_W'(reuse_inc) > CMP_W'(reuse_thr_r)) begin
      new_pol = POL_LRU;
    end else begin
      new_pol = POL_BRRIP;
    end
    lru_pos = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == way_r) begin
        lru_pos = lru_pos | lru_cur[w];
      end
    end
  end

  // modified row and result
  always_comb begin
    wr_row   = row_rd;
    victim   = '0;
    pol_out  = row_rd.pol;
    adv_lfsr = 1'b0;
    if (cmd_r == CMD_QUERY) begin
      if (row_rd.pol == POL_BRRIP) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          wr_row.rrpv[w*RRPV_W +: RRPV_W] = rrpv_aged[w];
        end
        // lowest way at max rrpv
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
          if (rrpv_aged[w] == RRPV_MAX) begin
            victim = WAY_W'(w);
          end
        end
      end else begin
        // stack is a permutation, so the bottom entry is unique
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (lru_cur[w] == POS_LAST) begin
            victim = WAY_W'(w);
          end
        end
      end
    end else begin
      wr_row.pol = new_pol;
      pol_out    = new_pol;
      if (wrap) begin
        wr_row.acc   = '0;
        wr_row.miss  = '0;
        wr_row.reuse = '0;
      end else begin
        wr_row.acc   = acc_inc[ACC_W-1:0];
        wr_row.miss  = miss_inc;
        wr_row.reuse = reuse_inc;
      end
      if (way_ok) begin
        if (new_pol == POL_BRRIP) begin
          adv_lfsr = !hit_r;
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == way_r) begin
              if (hit_r) begin
                wr_row.rrpv[w*RRPV_W +: RRPV_W] = RRPV_HIT;
              end else if (short_r) begin
                wr_row.rrpv[w*RRPV_W +: RRPV_W] = RRPV_SHORT;
              end else begin
                wr_row.rrpv[w*RRPV_W +: RRPV_W] = RRPV_MAX;
              end
            end
          end
        end else begin
          // move to front
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == way_r) begin
              wr_row.lru[w*POS_W +: POS_W] = '0;
            end else if (lru_cur[w] < lru_pos) begin
              wr_row.lru[w*POS_W +: POS_W] = lru_cur[w] + POS_W'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == SET_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = NEED_REDUCE ? ST_REDUCE : ST_CALC;
        end
      end
      ST_REDUCE: begin
        if (step_r) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      step_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      lfsr_r       <= LFSR_SEED;
      stream_thr_r <= STREAM_MISS_RESET;
      reuse_thr_r  <= REUSE_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_STREAM_MISS: stream_thr_r <= cfg_ch.data;
          REG_REUSE:       reuse_thr_r  <= cfg_ch.data;
          default: begin
          end
        endcase
      end

      if (out_ch.ready && !go) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + SET_W'(1);
        end
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r      <= cmd_t'(in_ch.cmd);
            way_r      <= in_ch.way;
            hit_r      <= in_ch.hit;
            cand_r     <= lfsr_step;
            set_r      <= in_set_idx;
            short_r    <= (lfsr_step[ODDS_W-1:0] == '0);
            src_set_r  <= in_set_wide;
            step_r     <= 1'b0;
          end
        end
        ST_REDUCE: begin
          step_r <= 1'b1;
          if (!step_r) begin
            quo_set_r  <= quo_set;
            quo_odds_r <= quo_odds;
          end else begin
            set_r   <= SET_W'(rem_set);
            short_r <= (rem_odds == '0);
          end
        end
        ST_READ: begin
        end
        ST_CALC: begin
          if (go) begin
            out_valid_r  <= 1'b1;
            out_victim_r <= victim;
            out_policy_r <= pol_out;
            if (adv_lfsr) begin
              lfsr_r <= cand_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/alru_ram.sv -----
module alru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/alru_checker.sv -----
module alru_checker
  import alru_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WAY_W-1:0] out_victim_way,
  input logic             out_policy_mode
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim_way)
                                && $stable(out_policy_mode))
    else $error("stalled result changed");

  // one transaction in the row pipeline at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while previous one in flight");

  // reset empties the output and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("not quiet after reset");

endmodule

bind adaptive_lru_brrip_replacement_top alru_checker u_alru_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_victim_way (out_ch.victim_way),
  .out_policy_mode(out_ch.policy_mode)
);

// ----- verif/adaptive_lru_brrip_replacement_top_test.sv -----
module adaptive_lru_brrip_replacement_top_test
  import alru_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // block sizing, taken from the package defaults the dut uses
  localparam int NSETS = DEF_NUM_SETS;
  localparam int NWAYS = DEF_NUM_WAYS;
  localparam int WIN   = DEF_WINDOW;
  localparam int ODDS  = DEF_INSERT_ODDS;

  // run shape
  localparam int DIR_N         = 17;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_ITEMS   = 135;
  localparam int HOLD_PHASE    = 2;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_GAP       = 11;

  // two hot sets with alternating index bits, so windows actually complete
  localparam logic [SET_IDX_W-1:0] HOT_SET_A = 11'h555;
  localparam logic [SET_IDX_W-1:0] HOT_SET_B = 11'h2AA;

  typedef struct packed {
    cmd_t                 cmd;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_W-1:0]     way;
    logic                 hit;
  } repl_req_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    policy_t          policy_mode;
  } repl_rsp_t;

  typedef struct {
    repl_req_t req;
    bit        typed;
    repl_rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  alru_in_if  in_ch ();
  alru_out_if out_ch ();
  alru_cfg_if cfg_ch ();

  adaptive_lru_brrip_replacement_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the per-set replacement state
  policy_t                 pol_mem   [NSETS];
  logic [RRPV_W*NWAYS-1:0] rrpv_mem  [NSETS];
  logic [POS_W*NWAYS-1:0]  lru_mem   [NSETS];
  logic [7:0]              win_acc   [NSETS];
  logic [7:0]              win_miss  [NSETS];
  logic [7:0]              win_reuse [NSETS];
  logic [LFSR_W-1:0]       fill_lfsr;
  logic [THR_W-1:0]        miss_thr;
  logic [THR_W-1:0]        reuse_thr;

  // results still owed by the dut, oldest first
  repl_rsp_t pending_rsp_q [$];

  int  mismatches = 0;
  bit  src_idle_on = 1'b0;
  bit  sink_idle_on = 1'b0;
  bit  long_hold_req = 1'b0;

  dir_row_t dir_tab [DIR_N];

  // what one transaction does to the predictor state, and the result it owes
  function automatic repl_rsp_t predict_replacement(input repl_req_t req);
    repl_rsp_t         rsp;
    int                s;
    int                w;
    int                mx;
    int                age;
    logic [7:0]        acc;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  p;
    logic [RRPV_W-1:0] v;
    s = int'(req.set_index) % NSETS;
    rsp.victim_way = '0;
    if (req.cmd == CMD_QUERY) begin
      if (pol_mem[s] == POL_BRRIP) begin
        // age just enough that some way reaches the distant value
        mx = 0;
        for (w = 0; w < NWAYS; w++)
          if (int'(rrpv_mem[s][RRPV_W*w +: RRPV_W]) > mx) mx = int'(rrpv_mem[s][RRPV_W*w +: RRPV_W]);
        age = int'(RRPV_MAX) - mx;
        for (w = 0; w < NWAYS; w++)
          rrpv_mem[s][RRPV_W*w +: RRPV_W] = RRPV_W'(int'(rrpv_mem[s][RRPV_W*w +: RRPV_W]) + age);
        for (w = NWAYS - 1; w >= 0; w--)
          if (rrpv_mem[s][RRPV_W*w +: RRPV_W] == RRPV_MAX) rsp.victim_way = WAY_W'(w);
      end else begin
        // ties go to the highest way
        mx = 0;
        for (w = 0; w < NWAYS; w++) begin
          p = lru_mem[s][POS_W*w +: POS_W];
          if (int'(p) >= mx) begin
            mx = int'(p);
            rsp.victim_way = WAY_W'(w);
          end
        end
      end
    end else begin
      acc = win_acc[s] + 8'd1;
      if (req.hit) win_reuse[s] = win_reuse[s] + 8'd1;
      else win_miss[s] = win_miss[s] + 8'd1;
      if (int'(acc) >= WIN) begin
        if (win_miss[s] > miss_thr) pol_mem[s] = POL_BRRIP;
        else if (win_reuse[s] > reuse_thr) pol_mem[s] = POL_LRU;
        else pol_mem[s] = POL_BRRIP;
        win_acc[s] = '0;
        win_miss[s] = '0;
        win_reuse[s] = '0;
      end else begin
        win_acc[s] = acc;
      end
      if (int'(req.way) < NWAYS) begin
        if (pol_mem[s] == POL_BRRIP) begin
          if (req.hit) begin
            v = RRPV_HIT;
          end else begin
            fill_lfsr = {fill_lfsr[0] ^ fill_lfsr[2] ^ fill_lfsr[3] ^ fill_lfsr[5],
                         fill_lfsr[LFSR_W-1:1]};
            v = (int'(fill_lfsr) % ODDS == 0) ? RRPV_SHORT : RRPV_MAX;
          end
          rrpv_mem[s][RRPV_W*int'(req.way) +: RRPV_W] = v;
        end else begin
          // move the way to mru, shift the younger ones down by one
          pos = lru_mem[s][POS_W*int'(req.way) +: POS_W];
          for (w = 0; w < NWAYS; w++) begin
            p = lru_mem[s][POS_W*w +: POS_W];
            if (w == int'(req.way)) lru_mem[s][POS_W*w +: POS_W] = '0;
            else if (p < pos) lru_mem[s][POS_W*w +: POS_W] = p + 1'b1;
          end
        end
      end
    end
    rsp.policy_mode = pol_mem[s];
    return rsp;
  endfunction

  // offer one transaction, after a random gap when source idling is on, queue its result once accepted
  task automatic offer_req(input repl_req_t req, input bit typed, input repl_rsp_t typed_rsp);
    int        gap;
    repl_rsp_t rsp;
    gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= req.cmd;
    in_ch.set_index <= req.set_index;
    in_ch.way       <= req.way;
    in_ch.hit       <= req.hit;
    do @(posedge clk); while (!in_ch.ready);
    rsp = predict_replacement(req);
    pending_rsp_q.push_back(typed ? typed_rsp : rsp);
  endtask

  // both threshold registers, back to back on the config channel
  task automatic write_thresholds(input logic [THR_W-1:0] stream_v,
                                  input logic [THR_W-1:0] reuse_v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_STREAM_MISS;
    cfg_ch.data  <= stream_v;
    do @(posedge clk); while (!cfg_ch.ready);
    miss_thr = stream_v;
    cfg_ch.index <= REG_REUSE;
    cfg_ch.data  <= reuse_v;
    do @(posedge clk); while (!cfg_ch.ready);
    reuse_thr = reuse_v;
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering, let every owed result arrive, then let the pipe settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus process
  initial begin
    int               i;
    int               ph;
    int               k;
    int               prim;
    int               sel;
    int               hit_pct [2];
    logic [THR_W-1:0] ph_stream;
    logic [THR_W-1:0] ph_reuse;
    repl_req_t        req;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_QUERY;
    in_ch.set_index <= '0;
    in_ch.way       <= '0;
    in_ch.hit       <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_STREAM_MISS;
    cfg_ch.data     <= '0;

    // predictor reset state
    for (i = 0; i < NSETS; i++) begin
      pol_mem[i]   = POL_BRRIP;
      win_acc[i]   = '0;
      win_miss[i]  = '0;
      win_reuse[i] = '0;
      for (k = 0; k < NWAYS; k++) begin
        rrpv_mem[i][RRPV_W*k +: RRPV_W] = RRPV_MAX;
        lru_mem[i][POS_W*k +: POS_W]    = POS_W'(k);
      end
    end
    fill_lfsr = LFSR_SEED;
    miss_thr  = STREAM_MISS_RESET;
    reuse_thr = REUSE_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: typed results only where the state is obvious
    dir_tab = '{
      // fresh sets, every way distant, victim is way zero
      '{'{CMD_QUERY,  11'd0,    4'd0,  1'b0}, 1'b1, '{4'd0, POL_BRRIP}},
      '{'{CMD_QUERY,  11'd2047, 4'd15, 1'b1}, 1'b1, '{4'd0, POL_BRRIP}},
      // hits at both way extremes, updates return way zero
      '{'{CMD_UPDATE, 11'd2047, 4'd15, 1'b1}, 1'b1, '{4'd0, POL_BRRIP}},
      '{'{CMD_UPDATE, 11'd2047, 4'd0,  1'b1}, 1'b1, '{4'd0, POL_BRRIP}},
      // ways zero and fifteen promoted, so lowest distant way is one
      '{'{CMD_QUERY,  11'd2047, 4'd0,  1'b0}, 1'b1, '{4'd1, POL_BRRIP}},
      // miss fill draws the lfsr
      '{'{CMD_UPDATE, 11'd2047, 4'd1,  1'b0}, 1'b1, '{4'd0, POL_BRRIP}},
      '{'{CMD_QUERY,  11'd2047, 4'd0,  1'b0}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_UPDATE, 11'd1024, 4'd10, 1'b0}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_UPDATE, 11'd1023, 4'd5,  1'b1}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_QUERY,  11'd1024, 4'd15, 1'b1}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_QUERY,  11'd1023, 4'd0,  1'b0}, 1'b0, '{4'd0, POL_BRRIP}},
      // repeated fills on one way, back to back same set
      '{'{CMD_UPDATE, 11'd682,  4'd15, 1'b0}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_UPDATE, 11'd682,  4'd15, 1'b0}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_QUERY,  11'd682,  4'd0,  1'b0}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_UPDATE, 11'd0,    4'd0,  1'b0}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_QUERY,  11'd0,    4'd0,  1'b0}, 1'b0, '{4'd0, POL_BRRIP}},
      '{'{CMD_UPDATE, 11'd1365, 4'd7,  1'b1}, 1'b0, '{4'd0, POL_BRRIP}}
    };
    for (i = 0; i < DIR_N; i++) offer_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
    wait_idle();

    // random phases, each with its own thresholds and traffic mix
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin
          ph_stream = 8'd128;
          ph_reuse  = 8'd0;
        end
        2: begin
          ph_stream = 8'd0;
          ph_reuse  = 8'd0;
        end
        3: begin
          ph_stream = 8'd255;
          ph_reuse  = 8'd255;
        end
        4: begin
          ph_stream = STREAM_MISS_RESET;
          ph_reuse  = REUSE_RESET;
        end
        5: begin
          ph_stream = THR_W'($urandom_range(0, WIN));
          ph_reuse  = THR_W'($urandom_range(0, WIN));
        end
        default: begin
          ph_stream = 8'd200;
          ph_reuse  = 8'd10;
        end
      endcase
      // phase zero keeps the reset values
      if (ph != 0) write_thresholds(ph_stream, ph_reuse);

      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      prim         = $urandom_range(0, 1);
      hit_pct[0]   = $urandom_range(0, 100);
      hit_pct[1]   = $urandom_range(0, 100);

      // receiver backs off for a long stretch while items keep coming
      if (ph == HOLD_PHASE) long_hold_req = 1'b1;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 85) begin
          sel = ($urandom_range(0, 99) < 70) ? prim : 1 - prim;
          req.set_index = (sel == 0) ? HOT_SET_A : HOT_SET_B;
        end else begin
          sel = $urandom_range(0, 1);
          req.set_index = SET_IDX_W'($urandom_range(0, NSETS - 1));
        end
        req.cmd = ($urandom_range(0, 99) < 75) ? CMD_UPDATE : CMD_QUERY;
        req.way = WAY_W'($urandom_range(0, NWAYS - 1));
        req.hit = ($urandom_range(0, 99) < hit_pct[sel]);
        offer_req(req, 1'b0, '0);
      end
      wait_idle();
    end

    if (mismatches == 0 && pending_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: random stalls per result, plus the one long hold-off
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // result checker, every accepted result against the oldest owed one
  repl_rsp_t got_rsp;
  repl_rsp_t want_rsp;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_rsp.victim_way  = out_ch.victim_way;
      got_rsp.policy_mode = policy_t'(out_ch.policy_mode);
      if (pending_rsp_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected transaction: victim %0d policy %0d",
                   got_rsp.victim_way, got_rsp.policy_mode);
        mismatches++;
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        if (got_rsp.victim_way !== want_rsp.victim_way ||
            got_rsp.policy_mode !== want_rsp.policy_mode) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: victim exp %0d got %0d, policy exp %0d got %0d",
                     want_rsp.victim_way, got_rsp.victim_way,
                     want_rsp.policy_mode, got_rsp.policy_mode);
          mismatches++;
        end
      end
    end
  end

  // watchdog, several times the slowest legal run
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
